@@ src/tpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle primitive assembly package
// Shared types, register indexes and sizing constants of the assembly block.
// ----------------------------------------------------------------------------
package tpa_pkg;

	localparam int INDEX_BITS  = 16;
	localparam int CNT_BITS    = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CNT_BITS-1:0] CNT_WRAP    = CNT_BITS'(65534);
	localparam logic [CNT_BITS-1:0] CNT_RESTART = CNT_BITS'(3);

	localparam logic [CFG_IDX_BITS-1:0] CFG_PRIM_MODE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_XX        = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_XY        = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TX        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_YX        = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_YY        = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TY        = 3'd6;

	localparam logic [1:0] KIND_NEXT   = 2'd0;
	localparam logic [1:0] KIND_OBJECT = 2'd1;
	localparam logic [1:0] KIND_BATCH  = 2'd2;

	typedef enum logic [1:0] {
		MODE_LIST  = 2'd0,
		MODE_STRIP = 2'd1,
		MODE_FAN   = 2'd2,
		MODE_NONE  = 2'd3
	} prim_mode_t;

	typedef struct packed {
		logic        [1:0]  kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [31:0] color;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
		logic        [15:0] texture_id;
		logic signed [15:0] draw_order;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic        [31:0] out_color;
		logic signed [31:0] out_u;
		logic signed [31:0] out_v;
		logic        [15:0] out_texture;
		logic signed [15:0] out_order;
		logic        [15:0] object_index;
		logic               last_of_triangle;
	} vtx_out_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [31:0] color;
		logic signed [31:0] u;
		logic signed [31:0] v;
	} vert_t;

	typedef struct packed {
		vert_t [2:0]             vtx;
		logic [15:0]             texture;
		logic signed [15:0]      order;
		logic [INDEX_BITS-1:0]   idx;
	} tri_t;

	typedef struct packed {
		logic signed [31:0] xx;
		logic signed [31:0] xy;
		logic signed [31:0] tx;
		logic signed [31:0] yx;
		logic signed [31:0] yy;
		logic signed [31:0] ty;
	} xform_t;

endpackage

@@ src/triangle_primitive_assembly_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle primitive assembly unit
// Groups a vertex stream into list, strip or fan triangles and emits each
// triangle as three affine-transformed vertices.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one vertex per transfer (kind, position, color, texcoords, tags).
//   out_* : one transformed vertex per transfer; the third of each triangle
//           carries last_of_triangle.
//   cfg_* : register writes, always ready; write only while the unit is idle.
// Path: an input transfer that completes a triangle writes it into the queue;
//   its three vertices then pass in order through the product register and
//   the output register, the first one leading.
// Throughput: an input that completes a triangle occupies the transform for
//   its three vertices, one vertex per cycle while out_stall is low; inputs
//   are taken every cycle while the queue is not full. A two-entry triangle
//   queue parts the front from the transform, so input flows until it fills.
// Reset: counters, held vertices, queue and pipeline clear; registers take
//   list mode and the identity transform.
// Stall on out_stall: the output register and transform stages hold, the
//   queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module triangle_primitive_assembly_unit
	import tpa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  vtx_in_t                 in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output vtx_out_t                out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]             cfg_data
);

	prim_mode_t mode_q;
	xform_t     xf_q;
	logic       q_full;
	logic       push;
	tri_t       tri_rec;
	logic       pop;
	logic       head_valid;
	tri_t       head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LIST;
			xf_q   <= '{xx: 32'sd65536, xy: '0, tx: '0, yx: '0, yy: 32'sd65536, ty: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PRIM_MODE: mode_q <= prim_mode_t'(cfg_data[1:0]);
				CFG_XX:        xf_q.xx <= cfg_data;
				CFG_XY:        xf_q.xy <= cfg_data;
				CFG_TX:        xf_q.tx <= cfg_data;
				CFG_YX:        xf_q.yx <= cfg_data;
				CFG_YY:        xf_q.yy <= cfg_data;
				CFG_TY:        xf_q.ty <= cfg_data;
				default: ;
			endcase
		end
	end

	tpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.mode     (mode_q),
		.q_full   (q_full),
		.push     (push),
		.tri_rec  (tri_rec)
	);

	tpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_data    (tri_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tpa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.xf         (xf_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

@@ src/tpa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Primitive assembly front
// Accepts vertices, tracks object and vertex counts, holds two vertices and
// hands each completed triangle to the triangle queue.
// ----------------------------------------------------------------------------
module tpa_front
	import tpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  vtx_in_t    in_data,
	input  prim_mode_t mode,
	input  logic       q_full,
	output logic       push,
	output tri_t       tri_rec
);

	vert_t                 held_q [2];
	logic [CNT_BITS-1:0]   cnt_q;
	logic [1:0]            ph_q;
	logic [INDEX_BITS-1:0] obj_q;

	vert_t                 cur;
	vert_t                 held0_n;
	vert_t                 held1_n;
	logic [CNT_BITS-1:0]   cnt;
	logic [CNT_BITS-1:0]   cnt_n;
	logic [1:0]            ph;
	logic [1:0]            ph_n;
	logic [INDEX_BITS-1:0] obj_n;
	logic                  emit;
	logic                  accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	assign cur.x     = in_data.pos_x;
	assign cur.y     = in_data.pos_y;
	assign cur.color = in_data.color;
	assign cur.u     = in_data.tex_u;
	assign cur.v     = in_data.tex_v;

	always_comb begin
		obj_n = obj_q;
		cnt   = cnt_q;
		ph    = ph_q;
		if (in_data.kind == KIND_BATCH) begin
			obj_n = INDEX_BITS'(1);
			cnt   = '0;
			ph    = '0;
		end else if (in_data.kind == KIND_OBJECT) begin
			obj_n = obj_q + 1'b1;
			cnt   = '0;
			ph    = '0;
		end

		case (mode)
			MODE_LIST:           emit = (ph == 2'd2);
			MODE_STRIP, MODE_FAN: emit = (cnt >= CNT_BITS'(2));
			default:             emit = 1'b0;
		endcase

		held0_n = held_q[0];
		held1_n = held_q[1];
		if (cnt == '0) begin
			held0_n = cur;
		end else if (cnt == CNT_BITS'(1)) begin
			held1_n = cur;
		end else begin
			case (mode)
				MODE_STRIP: begin
					held0_n = held_q[1];
					held1_n = cur;
				end
				MODE_FAN: held1_n = cur;
				MODE_LIST: begin
					if (ph == 2'd0)
						held0_n = cur;
					else if (ph == 2'd1)
						held1_n = cur;
				end
				default: ;
			endcase
		end

		cnt_n = (cnt >= CNT_WRAP) ? CNT_RESTART : cnt + 1'b1;
		ph_n  = (ph == 2'd2) ? 2'd0 : ph + 2'd1;

		tri_rec.vtx[0]  = held_q[0];
		tri_rec.vtx[1]  = held_q[1];
		tri_rec.vtx[2]  = cur;
		tri_rec.texture = in_data.texture_id;
		tri_rec.order   = in_data.draw_order;
		tri_rec.idx     = obj_n - 1'b1;
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q[0] <= '0;
			held_q[1] <= '0;
			cnt_q     <= '0;
			ph_q      <= '0;
			obj_q     <= '0;
		end else if (accept) begin
			held_q[0] <= held0_n;
			held_q[1] <= held1_n;
			cnt_q     <= cnt_n;
			ph_q      <= ph_n;
			obj_q     <= obj_n;
		end
	end

endmodule

@@ src/tpa_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle queue
// Short FIFO of completed triangles between the front and the back.
// ----------------------------------------------------------------------------
module tpa_queue
	import tpa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tri_t      wr_data,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output tri_t      head
);

	tri_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full        = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign head_valid  = (count_q != '0);
	assign head        = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("triangle queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("triangle queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("triangle queue count out of range");

endmodule

@@ src/tpa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Primitive assembly back
// Walks queued triangles one vertex a cycle, unless stalled, through a two
// stage affine transform: products in stage 1, sums into the output register.
// ----------------------------------------------------------------------------
module tpa_back
	import tpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  tri_t     head,
	output logic     pop,
	input  xform_t   xf,
	output logic     out_valid,
	input  logic     out_stall,
	output vtx_out_t out_data
);

	logic [1:0]         vsel_q;
	logic               adv;
	logic               inject;
	vert_t              vin;

	logic               valid_s1;
	logic [47:0]        p_xx_s1;
	logic [47:0]        p_xy_s1;
	logic [47:0]        p_yx_s1;
	logic [47:0]        p_yy_s1;
	vtx_out_t           pass_s1;

	logic               valid_s2;
	vtx_out_t           res_s2;
	vtx_out_t           res_d;
	logic [47:0]        sum_x;
	logic [47:0]        sum_y;

	assign adv    = !valid_s2 || !out_stall;
	assign inject = adv && head_valid;
	assign pop    = inject && (vsel_q == 2'd2);
	assign vin    = head.vtx[vsel_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsel_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= inject;
			valid_s2 <= valid_s1;
			if (inject)
				vsel_q <= (vsel_q == 2'd2) ? 2'd0 : vsel_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_xx_s1                  <= 48'(xf.xx * vin.x);
			p_xy_s1                  <= 48'(xf.xy * vin.y);
			p_yx_s1                  <= 48'(xf.yx * vin.x);
			p_yy_s1                  <= 48'(xf.yy * vin.y);
			pass_s1.out_x            <= '0;
			pass_s1.out_y            <= '0;
			pass_s1.out_color        <= vin.color;
			pass_s1.out_u            <= vin.u;
			pass_s1.out_v            <= vin.v;
			pass_s1.out_texture      <= head.texture;
			pass_s1.out_order        <= head.order;
			pass_s1.object_index     <= 16'(head.idx);
			pass_s1.last_of_triangle <= (vsel_q == 2'd2);
		end
	end

	assign sum_x = p_xx_s1 + p_xy_s1 + {xf.tx, 16'h0000};
	assign sum_y = p_yx_s1 + p_yy_s1 + {xf.ty, 16'h0000};

	always_comb begin
		res_d       = pass_s1;
		res_d.out_x = sum_x[47:16];
		res_d.out_y = sum_y[47:16];
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_d;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	a_pop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (vsel_q == 2'd0))
		else $error("vertex select not rewound after pop");

	a_last_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (valid_s1 && pass_s1.last_of_triangle))
		else $error("third vertex not marked last");

	a_vsel_range: assert property (@(posedge clk) disable iff (!arst_n)
		vsel_q != 2'd3)
		else $error("vertex select out of range");

endmodule
